/* rtl/ispf_pkg.sv */
// Shared types and constants for the IP-indexed stride prefetcher.
// No dependencies; imported by every module of the block.
package ispf_pkg;

   // Fixed field widths
   localparam int ADDR_W     = 64;
   localparam int CONF_W     = 8;
   localparam int THR_W      = 7;
   localparam int DEG_W      = 4;
   localparam int INTV_W     = 20;
   localparam int LIM_W      = 7;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 2;

   localparam logic signed [CONF_W-1:0] CONF_MAX = 8'sd127;

   // Register reset values
   localparam logic [THR_W-1:0]  THR_RST  = 7'd1;
   localparam logic [DEG_W-1:0]  DEG_RST  = 4'd3;
   localparam logic [INTV_W-1:0] INTV_RST = 20'd1024;
   localparam logic [LIM_W-1:0]  LIM_RST  = 7'd3;

   // Default geometry
   localparam int TRACKERS_DEF   = 16;
   localparam int BLOCK_BITS_DEF = 6;
   localparam int PAGE_BITS_DEF  = 12;
   localparam int MAX_DEGREE_DEF = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_DEGREE    = 2'd1,
      CSR_INTERVAL  = 2'd2,
      CSR_LIMIT     = 2'd3
   } ispf_csr_idx_type;

   typedef struct packed {
      logic [ADDR_W-1:0] access_addr;
      logic [ADDR_W-1:0] instr_ptr;
   } ispf_req_type;

   typedef struct packed {
      logic              pf_valid;
      logic [ADDR_W-1:0] prefetch_addr;
      logic              last;
   } ispf_rsp_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic accept;
      logic do_cull;
      logic do_lookup;
      logic do_calc;
      logic do_update;
      logic do_scan;
      logic do_vwrite;
      logic do_emit_pf;
      logic do_emit_empty;
   } ispf_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic is_cull;
      logic hit;
      logic scan_done;
      logic go;
      logic pf_last;
   } ispf_sts_type;

endpackage

/* rtl/ispf_ctrl.sv */
// Sequencing state machine of the stride prefetcher.
// Depends on ispf_pkg; drives the command struct into ispf_dpath.
module ispf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ispf_pkg::ispf_sts_type sts,
   output ispf_pkg::ispf_cmd_type cmd
);
   import ispf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CULL   = 8'b0000_0010,
      ST_LOOKUP = 8'b0000_0100,
      ST_CALC   = 8'b0000_1000,
      ST_UPDATE = 8'b0001_0000,
      ST_VSCAN  = 8'b0010_0000,
      ST_VWRITE = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } ispf_state_type;

   ispf_state_type state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = sts.is_cull ? ST_CULL : ST_LOOKUP;
            end
         end
         ST_CULL: begin
            cmd.do_cull       = 1'b1;
            cmd.do_emit_empty = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_LOOKUP: begin
            cmd.do_lookup = 1'b1;
            state_in      = sts.hit ? ST_CALC : ST_VSCAN;
         end
         ST_CALC: begin
            cmd.do_calc = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.do_update = 1'b1;
            if (sts.go) begin
               state_in = ST_EMIT;
            end else begin
               cmd.do_emit_empty = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_VSCAN: begin
            cmd.do_scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_VWRITE;
            end
         end
         ST_VWRITE: begin
            cmd.do_vwrite     = 1'b1;
            cmd.do_emit_empty = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_EMIT: begin
            cmd.do_emit_pf = 1'b1;
            if (sts.pf_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> busy)
      else $error("accepted request did not raise busy");

   a_emit_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && !sts.pf_last |=> (state_ff == ST_EMIT))
      else $error("prefetch burst cut short");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VSCAN) && sts.scan_done |=> (state_ff == ST_VWRITE))
      else $error("victim scan did not end in a replace");

endmodule

/* rtl/ispf_dpath.sv */
// Tracker table, config registers and prefetch address generator.
// Depends on ispf_pkg; commanded by ispf_ctrl.
module ispf_dpath #(
   parameter int TRACKERS   = ispf_pkg::TRACKERS_DEF,
   parameter int BLOCK_BITS = ispf_pkg::BLOCK_BITS_DEF,
   parameter int PAGE_BITS  = ispf_pkg::PAGE_BITS_DEF,
   parameter int MAX_DEGREE = ispf_pkg::MAX_DEGREE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ispf_pkg::ispf_req_type              req_data,
   input  logic                                csr_we,
   input  logic [ispf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ispf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  ispf_pkg::ispf_cmd_type              cmd,
   output ispf_pkg::ispf_sts_type              sts,
   output logic                                rsp_strobe,
   output ispf_pkg::ispf_rsp_type              rsp_data
);
   import ispf_pkg::*;

   localparam int IDX_W    = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
   localparam int LINE_W   = ADDR_W - BLOCK_BITS;
   localparam int STRIDE_W = LINE_W + 1;
   localparam int CNT_W    = $clog2(MAX_DEGREE + 1);

   // Config registers
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [DEG_W-1:0]  deg_cfg_ff, deg_cfg_in;
   logic [INTV_W-1:0] intv_cfg_ff, intv_cfg_in;
   logic [LIM_W-1:0]  lim_ff, lim_in;
   logic [INTV_W-1:0] interval_ff, interval_in;

   // Tracker table
   logic [ADDR_W-1:0]          ip_ff     [TRACKERS];
   logic [ADDR_W-1:0]          ip_in     [TRACKERS];
   logic [LINE_W-1:0]          line_ff   [TRACKERS];
   logic [LINE_W-1:0]          line_in   [TRACKERS];
   logic [STRIDE_W-1:0]        stride_ff [TRACKERS];
   logic [STRIDE_W-1:0]        stride_in [TRACKERS];
   logic signed [CONF_W-1:0]   conf_ff   [TRACKERS];
   logic signed [CONF_W-1:0]   conf_in   [TRACKERS];

   // Working registers
   ispf_req_type             req_ff, req_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic signed [CONF_W-1:0] best_conf_ff, best_conf_in;
   logic [STRIDE_W-1:0]      diff_ff, diff_in;
   logic [LINE_W-1:0]        cand_ff, cand_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         deg_ff, deg_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   ispf_rsp_type             rsp_ff, rsp_in;

   // Combinational helpers
   logic [TRACKERS-1:0]      hit_vec;
   logic                     hit_any;
   logic [IDX_W-1:0]         hit_idx;
   logic [LINE_W-1:0]        req_line;
   logic [LINE_W-1:0]        sel_line;
   logic [STRIDE_W-1:0]      sel_stride;
   logic signed [CONF_W-1:0] sel_conf;
   logic signed [CONF_W-1:0] conf_inc;
   logic signed [CONF_W-1:0] thr_s;
   logic signed [CONF_W-1:0] lim_s;
   logic                     same_stride;
   logic                     diff_zero;
   logic [LINE_W-1:0]        diff_line;
   logic [LINE_W-1:0]        first_line;
   logic [LINE_W-1:0]        next_line;
   logic [CNT_W-1:0]         deg_clamp;

   function automatic logic in_page(input logic [LINE_W-1:0] ln,
                                    input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] pa;
      pa = {ln, {BLOCK_BITS{1'b0}}};
      return pa[ADDR_W-1:PAGE_BITS] == addr[ADDR_W-1:PAGE_BITS];
   endfunction

   assign req_line   = req_ff.access_addr[ADDR_W-1:BLOCK_BITS];
   assign sel_line   = line_ff[ptr_ff];
   assign sel_stride = stride_ff[ptr_ff];
   assign sel_conf   = conf_ff[ptr_ff];
   assign thr_s      = signed'({1'b0, thr_ff});
   assign lim_s      = signed'({1'b0, lim_ff});

   // CAM match, lowest index wins
   always_comb begin
      hit_idx = '0;
      for (int e = 0; e < TRACKERS; e++) begin
         hit_vec[e] = (ip_ff[e] == req_ff.instr_ptr);
      end
      for (int e = TRACKERS - 1; e >= 0; e--) begin
         if (hit_vec[e]) begin
            hit_idx = IDX_W'(e);
         end
      end
   end
   assign hit_any = |hit_vec;

   assign same_stride = (diff_ff == sel_stride);
   assign diff_zero   = (diff_ff == '0);
   assign conf_inc    = (sel_conf == CONF_MAX) ? sel_conf : sel_conf + CONF_W'(1);
   assign diff_line   = diff_ff[LINE_W-1:0];
   assign first_line  = req_line + diff_line;
   assign next_line   = cand_ff + diff_line;
   assign deg_clamp   = (int'(deg_cfg_ff) > MAX_DEGREE) ? CNT_W'(MAX_DEGREE)
                                                        : CNT_W'(deg_cfg_ff);

   assign sts.is_cull   = (interval_ff >= intv_cfg_ff);
   assign sts.hit       = hit_any;
   assign sts.scan_done = (ptr_ff == IDX_W'(TRACKERS - 1));
   assign sts.go        = !diff_zero && same_stride && (conf_inc > thr_s) &&
                          (deg_clamp != '0) && in_page(first_line, req_ff.access_addr);
   assign sts.pf_last   = ((cnt_ff + CNT_W'(1)) == deg_ff) ||
                          !in_page(next_line, req_ff.access_addr);

   always_comb begin
      thr_in        = thr_ff;
      deg_cfg_in    = deg_cfg_ff;
      intv_cfg_in   = intv_cfg_ff;
      lim_in        = lim_ff;
      interval_in   = interval_ff;
      ip_in         = ip_ff;
      line_in       = line_ff;
      stride_in     = stride_ff;
      conf_in       = conf_ff;
      req_in        = req_ff;
      ptr_in        = ptr_ff;
      best_idx_in   = best_idx_ff;
      best_conf_in  = best_conf_ff;
      diff_in       = diff_ff;
      cand_in       = cand_ff;
      cnt_in        = cnt_ff;
      deg_in        = deg_ff;
      rsp_strobe_in = cmd.do_emit_pf | cmd.do_emit_empty;
      rsp_in        = rsp_ff;

      if (csr_we) begin
         case (ispf_csr_idx_type'(csr_index))
            CSR_THRESHOLD: thr_in      = csr_wdata[THR_W-1:0];
            CSR_DEGREE:    deg_cfg_in  = csr_wdata[DEG_W-1:0];
            CSR_INTERVAL:  intv_cfg_in = csr_wdata[INTV_W-1:0];
            CSR_LIMIT:     lim_in      = csr_wdata[LIM_W-1:0];
            default:       ;
         endcase
      end

      if (cmd.accept) begin
         req_in      = req_data;
         interval_in = sts.is_cull ? '0 : interval_ff + INTV_W'(1);
      end

      if (cmd.do_cull) begin
         for (int e = 0; e < TRACKERS; e++) begin
            if (conf_ff[e] < lim_s) begin
               ip_in[e]     = '0;
               line_in[e]   = '0;
               stride_in[e] = '0;
               conf_in[e]   = '0;
            end
         end
      end

      if (cmd.do_lookup) begin
         ptr_in       = hit_any ? hit_idx : '0;
         best_idx_in  = '0;
         best_conf_in = conf_ff[0];
      end

      if (cmd.do_calc) begin
         diff_in = {1'b0, req_line} - {1'b0, sel_line};
      end

      if (cmd.do_update) begin
         if (!diff_zero) begin
            line_in[ptr_ff]   = req_line;
            stride_in[ptr_ff] = diff_ff;
            conf_in[ptr_ff]   = same_stride ? conf_inc : '0;
         end
         cand_in = first_line;
         cnt_in  = '0;
         deg_in  = deg_clamp;
      end

      if (cmd.do_scan) begin
         if (sel_conf < best_conf_ff) begin
            best_idx_in  = ptr_ff;
            best_conf_in = sel_conf;
         end
         ptr_in = ptr_ff + IDX_W'(1);
      end

      if (cmd.do_vwrite) begin
         ip_in[best_idx_ff]     = req_ff.instr_ptr;
         line_in[best_idx_ff]   = req_line;
         stride_in[best_idx_ff] = '0;
         conf_in[best_idx_ff]   = '0;
      end

      if (cmd.do_emit_empty) begin
         rsp_in.pf_valid      = 1'b0;
         rsp_in.prefetch_addr = '0;
         rsp_in.last          = 1'b1;
      end

      if (cmd.do_emit_pf) begin
         rsp_in.pf_valid      = 1'b1;
         rsp_in.prefetch_addr = {cand_ff, {BLOCK_BITS{1'b0}}};
         rsp_in.last          = sts.pf_last;
         cand_in              = next_line;
         cnt_in               = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= THR_RST;
         deg_cfg_ff    <= DEG_RST;
         intv_cfg_ff   <= INTV_RST;
         lim_ff        <= LIM_RST;
         interval_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int e = 0; e < TRACKERS; e++) begin
            ip_ff[e]     <= '0;
            line_ff[e]   <= '0;
            stride_ff[e] <= '0;
            conf_ff[e]   <= CONF_W'(-e);
         end
      end else begin
         thr_ff        <= thr_in;
         deg_cfg_ff    <= deg_cfg_in;
         intv_cfg_ff   <= intv_cfg_in;
         lim_ff        <= lim_in;
         interval_ff   <= interval_in;
         rsp_strobe_ff <= rsp_strobe_in;
         ip_ff         <= ip_in;
         line_ff       <= line_in;
         stride_ff     <= stride_in;
         conf_ff       <= conf_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      ptr_ff       <= ptr_in;
      best_idx_ff  <= best_idx_in;
      best_conf_ff <= best_conf_in;
      diff_ff      <= diff_in;
      cand_ff      <= cand_in;
      cnt_ff       <= cnt_in;
      deg_ff       <= deg_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.last |=> rsp_strobe_ff)
      else $error("gap inside a prefetch burst");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.pf_valid |-> rsp_ff.last && (rsp_ff.prefetch_addr == '0))
      else $error("malformed empty response");

   a_deg_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.do_emit_pf |-> (cnt_ff < deg_ff))
      else $error("prefetch count exceeds degree");

endmodule

/* rtl/ip_stride_prefetcher_unit.sv */
// Top level of the IP-indexed stride prefetcher.
// Depends on ispf_pkg, ispf_ctrl and ispf_dpath.
//
// One demand request (access address and instruction pointer) is taken at a
// clock edge where start is high and busy is low; busy stays high until the
// unit can take the next one. Each request produces one or more responses on
// rsp_data, each valid for exactly one cycle while rsp_strobe is high, in
// order, with last set on the final one. The receiver cannot stall: it must
// take every strobed response. A request that trains a known tracker runs
// the lookup / stride compute / update sequence and then, if it prefetches,
// the one-address-per-cycle generator, which issues at most degree
// addresses (degree capped at MAX_DEGREE). On a tracker miss the replacement
// victim is found by walking the confidence column one entry per cycle.
// Responses are registered: an empty response shows in the cycle after the
// cull, update or replace step that decides it, and the first prefetch is
// registered out of the emit step that follows the update step.
// Config registers (threshold, degree, cull interval, cull limit) are
// written through csr_we / csr_index / csr_wdata; the user must write them
// only while the unit is idle, which the block itself does not enforce.
module ip_stride_prefetcher_unit #(
   parameter int TRACKERS   = ispf_pkg::TRACKERS_DEF,
   parameter int BLOCK_BITS = ispf_pkg::BLOCK_BITS_DEF,
   parameter int PAGE_BITS  = ispf_pkg::PAGE_BITS_DEF,
   parameter int MAX_DEGREE = ispf_pkg::MAX_DEGREE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  ispf_pkg::ispf_req_type          req_data,
   // response channel
   output logic                            rsp_strobe,
   output ispf_pkg::ispf_rsp_type          rsp_data,
   // config write port
   input  logic                            csr_we,
   input  logic [ispf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ispf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ispf_pkg::*;

   // controller <-> datapath
   ispf_cmd_type cmd;
   ispf_sts_type sts;

   // Sequencer: accept, then cull, or lookup and train or replace, then emit.
   ispf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Tracker table, config registers and address generator.
   ispf_dpath #(
      .TRACKERS   (TRACKERS),
      .BLOCK_BITS (BLOCK_BITS),
      .PAGE_BITS  (PAGE_BITS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the IP-indexed stride prefetcher top level.
// Depends on ispf_pkg and ip_stride_prefetcher_unit; carries its own shadow
// of the tracker table to predict each response the directed table does not type in.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ispf_pkg::*;

   localparam int  TRK       = TRACKERS_DEF;
   localparam int  BLK       = BLOCK_BITS_DEF;
   localparam int  PG        = PAGE_BITS_DEF;
   localparam int  MAXDEG    = MAX_DEGREE_DEF;
   localparam int  NSTREAM   = 24;     // more streams than trackers forces eviction
   localparam int  PHASES    = 5;
   localparam int  PHASE_LEN = 50;
   localparam int  DRAIN_CYC = TRK + 16;
   localparam int  LIMIT_CYC = 300000;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // one row of the directed table: a request or a register write
   typedef struct {
      row_kind_type     kind;
      ispf_req_type     req;
      logic             fixed;   // response typed in below, not predicted
      ispf_rsp_type     want;
      ispf_csr_idx_type idx;
      logic [19:0]      val;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   ispf_req_type     req_data;
   logic             rsp_strobe;
   ispf_rsp_type     rsp_data;
   logic             csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ip_stride_prefetcher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the tracker table and the config registers
   // ---------------------------------------------------------------------
   logic [63:0]        trk_ip     [TRK];
   logic [57:0]        trk_line   [TRK];
   logic [58:0]        trk_stride [TRK];   // signed line stride, two's complement
   logic signed [7:0]  trk_conf   [TRK];
   logic [19:0]        intv_cnt;

   logic [THR_W-1:0]   sh_thr;
   logic [DEG_W-1:0]   sh_deg;
   logic [INTV_W-1:0]  sh_intv;
   logic [LIM_W-1:0]   sh_lim;

   ispf_rsp_type pending_pf [$];   // responses still owed by the block
   ispf_rsp_type fresh_pf   [$];   // responses of the request just taken

   int mismatch_cnt = 0;
   int req_count    = 0;
   int pf_seen      = 0;
   int empty_seen   = 0;
   int cull_count   = 0;
   int max_burst_pf = 0;
   int cycles       = 0;
   int burst_left   = 0;

   dir_row_type dir_rows [$];
   logic [63:0] s_ip   [NSTREAM];
   logic [63:0] s_addr [NSTREAM];
   longint      s_step [NSTREAM];   // byte step of each synthetic load stream

   ispf_rsp_type mon_want;

   task automatic shadow_reset();
      for (int e = 0; e < TRK; e++) begin
         trk_ip[e]     = '0;
         trk_line[e]   = '0;
         trk_stride[e] = '0;
         trk_conf[e]   = 8'(-e);
      end
      intv_cnt = '0;
      sh_thr   = THR_RST;
      sh_deg   = DEG_RST;
      sh_intv  = INTV_RST;
      sh_lim   = LIM_RST;
   endtask

   // Works out the responses of one accepted request into fresh_pf and
   // updates the shadow table.
   task automatic predict_prefetches(input ispf_req_type r);
      logic [57:0]  line;
      logic [57:0]  tgt;
      logic [58:0]  diff;
      logic [63:0]  pa;
      ispf_rsp_type item;
      int           hit;
      int           vic;
      int           ndeg;
      logic         stop;
      fresh_pf.delete();
      line = r.access_addr[63:BLK];
      if (intv_cnt < sh_intv) begin
         intv_cnt = intv_cnt + 1'b1;
         hit = -1;
         for (int e = 0; e < TRK; e++) begin
            if (hit < 0 && trk_ip[e] == r.instr_ptr) hit = e;
         end
         if (hit < 0) begin
            // replace the least confident tracker, lowest index on a tie
            vic = 0;
            for (int e = 1; e < TRK; e++) begin
               if (trk_conf[e] < trk_conf[vic]) vic = e;
            end
            trk_ip[vic]     = r.instr_ptr;
            trk_line[vic]   = line;
            trk_stride[vic] = '0;
            trk_conf[vic]   = '0;
         end else begin
            diff = {1'b0, line} - {1'b0, trk_line[hit]};
            if (diff != '0) begin
               if (diff == trk_stride[hit]) begin
                  if (trk_conf[hit] < CONF_MAX) trk_conf[hit] = trk_conf[hit] + 8'sd1;
                  if (int'(trk_conf[hit]) > int'(sh_thr)) begin
                     ndeg = (int'(sh_deg) > MAXDEG) ? MAXDEG : int'(sh_deg);
                     stop = 1'b0;
                     for (int k = 1; k <= ndeg; k++) begin
                        tgt = line + diff[57:0] * 58'(k);
                        pa  = {tgt, {BLK{1'b0}}};
                        // first address off the demand page ends the run
                        if (pa[63:PG] != r.access_addr[63:PG]) stop = 1'b1;
                        if (!stop) begin
                           item.pf_valid      = 1'b1;
                           item.prefetch_addr = pa;
                           item.last          = 1'b0;
                           fresh_pf.push_back(item);
                        end
                     end
                  end
               end else begin
                  trk_conf[hit] = '0;
               end
               trk_line[hit]   = line;
               trk_stride[hit] = diff;
            end
         end
      end else begin
         // cull pass instead of training
         intv_cnt = '0;
         cull_count++;
         for (int e = 0; e < TRK; e++) begin
            if (int'(trk_conf[e]) < int'(sh_lim)) begin
               trk_ip[e]     = '0;
               trk_line[e]   = '0;
               trk_stride[e] = '0;
               trk_conf[e]   = '0;
            end
         end
      end
      if (fresh_pf.size() == 0) begin
         item = '{pf_valid: 1'b0, prefetch_addr: '0, last: 1'b1};
         fresh_pf.push_back(item);
      end else begin
         fresh_pf[fresh_pf.size()-1].last = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH @%0t %s: got %h expected %h", $realtime, what, got, want);
      mismatch_cnt++;
   endtask

   // ---------------------------------------------------------------------
   // Response checker: every strobed response is taken, no backpressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_pf.size() == 0) begin
            report_mismatch("response with no request pending", rsp_data.prefetch_addr, '0);
         end else begin
            mon_want = pending_pf.pop_front();
            if (rsp_data.pf_valid !== mon_want.pf_valid)
               report_mismatch("pf_valid", 64'(rsp_data.pf_valid), 64'(mon_want.pf_valid));
            if (rsp_data.prefetch_addr !== mon_want.prefetch_addr)
               report_mismatch("prefetch_addr", rsp_data.prefetch_addr, mon_want.prefetch_addr);
            if (rsp_data.last !== mon_want.last)
               report_mismatch("last", 64'(rsp_data.last), 64'(mon_want.last));
         end
         if (rsp_data.pf_valid === 1'b1) pf_seen++;
         else empty_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYC) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  pending_pf.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Sender works in bursts; roughly a third of the bursts follow with no gap.
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Drives one request, waits for the accept edge and queues what it owes.
   task automatic issue_request(input ispf_req_type r, input logic fixed,
                                input ispf_rsp_type want);
      pace();
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_prefetches(r);
      if (fresh_pf.size() > max_burst_pf) max_burst_pf = fresh_pf.size();
      if (fixed) pending_pf.push_back(want);
      else foreach (fresh_pf[i]) pending_pf.push_back(fresh_pf[i]);
      req_count++;
   endtask

   // Registers change only with the block quiet and nothing owed.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pf.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic csr_write(input ispf_csr_idx_type idx, input logic [19:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_THRESHOLD: sh_thr  = val[THR_W-1:0];
         CSR_DEGREE:    sh_deg  = val[DEG_W-1:0];
         CSR_INTERVAL:  sh_intv = val[INTV_W-1:0];
         CSR_LIMIT:     sh_lim  = val[LIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // directed table builders
   task automatic add_req(input logic [63:0] addr, input logic [63:0] ip);
      dir_row_type row;
      row = '{kind: ROW_REQ, req: '{access_addr: addr, instr_ptr: ip}, fixed: 1'b0,
              want: '0, idx: CSR_THRESHOLD, val: '0};
      dir_rows.push_back(row);
   endtask

   // request whose single response can be read off directly
   task automatic add_fixed(input logic [63:0] addr, input logic [63:0] ip,
                            input logic [63:0] pa);
      dir_row_type row;
      row = '{kind: ROW_REQ, req: '{access_addr: addr, instr_ptr: ip}, fixed: 1'b1,
              want: '{pf_valid: (pa != '0), prefetch_addr: pa, last: 1'b1},
              idx: CSR_THRESHOLD, val: '0};
      dir_rows.push_back(row);
   endtask

   task automatic add_csr(input ispf_csr_idx_type idx, input logic [19:0] val);
      dir_row_type row;
      row = '{kind: ROW_CSR, req: '0, fixed: 1'b0, want: '0, idx: idx, val: val};
      dir_rows.push_back(row);
   endtask

   task automatic new_stride(input int s);
      longint lines;
      lines = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 1) == 1) lines = -lines;
      s_step[s] = lines * 64;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      ispf_req_type r;
      int           s;
      int           pick;
      logic [19:0]  intv_pick;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_wdata = '0;
      shadow_reset();

      // After reset: all trackers hold ip 0, so ip 0 hits entry 0 on the same line.
      add_fixed(64'h0, 64'h0, 64'h0);
      // all-ones address and pointer: a plain miss
      add_fixed('1, '1, 64'h0);
      // unit stride walking up to the end of a page
      add_fixed(64'h2E40, 64'h0000_7F00_0000_1234, 64'h0);
      add_fixed(64'h2E80, 64'h0000_7F00_0000_1234, 64'h0);
      add_fixed(64'h2EC0, 64'h0000_7F00_0000_1234, 64'h0);
      add_req  (64'h2F00, 64'h0000_7F00_0000_1234);
      add_req  (64'h2F40, 64'h0000_7F00_0000_1234);
      add_fixed(64'h2F80, 64'h0000_7F00_0000_1234, 64'h2FC0);
      add_fixed(64'h2FC0, 64'h0000_7F00_0000_1234, 64'h0);   // next line is off page
      add_fixed(64'h2FC8, 64'h0000_7F00_0000_1234, 64'h0);   // same line again
      // negative stride hitting the page start
      add_fixed(64'h5100, 64'h8000_0000_0000_0004, 64'h0);
      add_fixed(64'h50C0, 64'h8000_0000_0000_0004, 64'h0);
      add_fixed(64'h5080, 64'h8000_0000_0000_0004, 64'h0);
      add_req  (64'h5040, 64'h8000_0000_0000_0004);
      add_req  (64'h4FC0, 64'h8000_0000_0000_0004);
      // top of the address space: line arithmetic wraps to zero
      add_fixed(64'hFFFF_FFFF_FFFF_FE80, 64'h0000_0000_0BAD_F00D, 64'h0);
      add_fixed(64'hFFFF_FFFF_FFFF_FEC0, 64'h0000_0000_0BAD_F00D, 64'h0);
      add_fixed(64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0000_0BAD_F00D, 64'h0);
      add_req  (64'hFFFF_FFFF_FFFF_FF40, 64'h0000_0000_0BAD_F00D);
      // lowest threshold, degree above the cap: eight prefetches
      add_csr(CSR_THRESHOLD, 20'd0);
      add_csr(CSR_DEGREE, 20'd15);
      add_fixed(64'h7000, 64'h1111, 64'h0);
      add_fixed(64'h7080, 64'h1111, 64'h0);
      add_req  (64'h7100, 64'h1111);
      // zero degree: trained but nothing issued
      add_csr(CSR_DEGREE, 20'd0);
      add_fixed(64'h7180, 64'h1111, 64'h0);
      // zero interval with the top limit: every request is a cull
      add_csr(CSR_INTERVAL, 20'd0);
      add_csr(CSR_LIMIT, 20'd127);
      add_fixed(64'h7200, 64'h1111, 64'h0);
      add_fixed(64'h7240, 64'h1111, 64'h0);
      // remaining extremes
      add_csr(CSR_THRESHOLD, 20'd127);
      add_csr(CSR_DEGREE, 20'd8);
      add_csr(CSR_INTERVAL, 20'hFFFFF);
      add_csr(CSR_LIMIT, 20'd0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(dir_rows[i].idx, dir_rows[i].val);
         end else begin
            issue_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
         end
      end

      // synthetic load streams for the random part
      for (int k = 0; k < NSTREAM; k++) begin
         s_ip[k]   = {$urandom, $urandom};
         s_addr[k] = {$urandom, $urandom};
         new_stride(k);
      end
      s = 0;

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         // upper data bits beyond each register are noise the block must drop
         csr_write(CSR_THRESHOLD, {13'($urandom), 7'($urandom_range(0, 3))});
         csr_write(CSR_DEGREE, {16'($urandom),
                   ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(1, 8))});
         case ($urandom_range(0, 3))
            0:       intv_pick = 20'd1;
            1:       intv_pick = 20'($urandom_range(3, 30));
            2:       intv_pick = 20'($urandom_range(100, 1000));
            default: intv_pick = 20'hFFFFF;
         endcase
         csr_write(CSR_INTERVAL, intv_pick);
         csr_write(CSR_LIMIT, {13'($urandom), 7'($urandom_range(0, 4))});

         for (int n = 0; n < PHASE_LEN; n++) begin
            // runs on one stream let trackers build confidence
            if ($urandom_range(0, 9) >= 7) s = $urandom_range(0, NSTREAM - 1);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               if ($urandom_range(0, 9) == 0) new_stride(s);
               if ($urandom_range(0, 19) != 0) s_addr[s] = s_addr[s] + s_step[s];
               r.instr_ptr   = s_ip[s];
               r.access_addr = {s_addr[s][63:BLK], BLK'($urandom)};
            end else if (pick < 90) begin
               // stream jumps elsewhere
               s_addr[s]     = {$urandom, $urandom};
               r.instr_ptr   = s_ip[s];
               r.access_addr = s_addr[s];
            end else begin
               r.instr_ptr   = ($urandom_range(0, 4) == 0) ? 64'h0 : {$urandom, $urandom};
               r.access_addr = {$urandom, $urandom};
            end
            issue_request(r, 1'b0, '0);
         end
      end

      wait_idle();
      $display("covered %0d requests: %0d prefetch and %0d empty responses, %0d cull passes",
               req_count, pf_seen, empty_seen, cull_count);
      $display("largest prefetch run %0d, %0d mismatches", max_burst_pf, mismatch_cnt);
      if (mismatch_cnt == 0 && pending_pf.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ispf_pkg.sv
rtl/ispf_ctrl.sv
rtl/ispf_dpath.sv
rtl/ip_stride_prefetcher_unit.sv
tb/tb.sv
